/* sv/bhc_pkg.sv */
// Package for the button hold classifier: command, class and mode codes,
// and the item, configuration and result types shared by the modules.
// Depends on nothing.
package bhc_pkg;

  localparam int CountW = 16;
  localparam logic [CountW-1:0] CountMax = '1;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_PRESS = 2'd1;
  localparam logic [1:0] CMD_ACK   = 2'd2;

  localparam logic [1:0] CLASS_NONE = 2'd0;
  localparam logic [1:0] CLASS_HOLD = 2'd1;
  localparam logic [1:0] CLASS_LONG = 2'd2;

  localparam logic [1:0] MODE_IDLE     = 2'd0;
  localparam logic [1:0] MODE_TRANSMIT = 2'd1;
  localparam logic [1:0] MODE_RECORD   = 2'd2;

  localparam logic [1:0] REG_MIN_HOLD       = 2'd0;
  localparam logic [1:0] REG_LONG_HOLD      = 2'd1;
  localparam logic [1:0] REG_VERY_LONG_HOLD = 2'd2;

  localparam logic [CountW-1:0] MinHoldReset      = 16'd50;
  localparam logic [CountW-1:0] LongHoldReset     = 16'd1000;
  localparam logic [CountW-1:0] VeryLongHoldReset = 16'd3000;

  typedef struct packed {
    logic [1:0] cmd;
    logic       button_level;
  } in_item_t;

  typedef struct packed {
    logic [1:0] press_class;
    logic [1:0] op_mode;
    logic       mode_changed;
    logic       timing_active;
  } out_item_t;

  typedef struct packed {
    logic [CountW-1:0] min_hold_ticks;
    logic [CountW-1:0] long_hold_ticks;
    logic [CountW-1:0] very_long_hold_ticks;
  } cfg_t;

endpackage

/* sv/bhc_in_if.sv */
// Input channel of the button hold classifier: valid, ready and one item.
// Depends on nothing.
interface bhc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic       button_level;

  modport source (output valid, output cmd, output button_level, input ready);
  modport sink (input valid, input cmd, input button_level, output ready);
endinterface

/* sv/bhc_out_if.sv */
// Result channel of the button hold classifier: valid, ready and one result.
// Depends on nothing.
interface bhc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] press_class;
  logic [1:0] op_mode;
  logic       mode_changed;
  logic       timing_active;

  modport source (output valid, output press_class, output op_mode,
                  output mode_changed, output timing_active, input ready);
  modport sink (input valid, input press_class, input op_mode,
                input mode_changed, input timing_active, output ready);
endinterface

/* sv/bhc_core.sv */
// State and next-state logic of the button hold classifier: counters,
// timing flag, pending class and system mode. Depends on bhc_pkg.
module bhc_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  bhc_pkg::in_item_t item,
  input  bhc_pkg::cfg_t     cfg,
  output bhc_pkg::out_item_t res
);

  logic [bhc_pkg::CountW-1:0] held_r, held_nxt;
  logic [bhc_pkg::CountW-1:0] rel_r, rel_nxt;
  logic                       last_r, last_nxt;
  logic                       running_r, running_nxt;
  logic [1:0]                 pending_r, pending_nxt;
  logic [1:0]                 mode_r, mode_nxt;
  logic                       changed;
  logic [bhc_pkg::CountW-1:0] held_inc, rel_inc;

  assign held_inc = (held_r == bhc_pkg::CountMax) ? held_r : held_r + 1'b1;
  assign rel_inc  = (rel_r == bhc_pkg::CountMax) ? rel_r : rel_r + 1'b1;

  always_comb begin
    held_nxt    = held_r;
    rel_nxt     = rel_r;
    last_nxt    = last_r;
    running_nxt = running_r;
    pending_nxt = pending_r;
    mode_nxt    = mode_r;
    changed     = 1'b0;
    case (item.cmd)
      bhc_pkg::CMD_TICK: begin
        if (running_r) begin
          last_nxt = item.button_level;
          if (last_r == item.button_level && !item.button_level) begin
            held_nxt = held_inc;
            if (held_inc >= cfg.very_long_hold_ticks) begin
              mode_nxt    = (mode_r >= bhc_pkg::MODE_RECORD) ? bhc_pkg::MODE_IDLE
                                                             : mode_r + 1'b1;
              changed     = 1'b1;
              pending_nxt = bhc_pkg::CLASS_NONE;
              held_nxt    = '0;
              rel_nxt     = '0;
              running_nxt = 1'b0;
            end
          end else if (last_r == item.button_level && item.button_level) begin
            rel_nxt = rel_inc;
            if (rel_inc >= cfg.min_hold_ticks) begin
              if (held_r >= cfg.long_hold_ticks) begin
                pending_nxt = bhc_pkg::CLASS_LONG;
              end else if (held_r >= cfg.min_hold_ticks) begin
                pending_nxt = bhc_pkg::CLASS_HOLD;
              end
              held_nxt    = '0;
              rel_nxt     = '0;
              running_nxt = 1'b0;
            end
          end
        end
      end
      bhc_pkg::CMD_PRESS: begin
        if (pending_r == bhc_pkg::CLASS_NONE) begin
          running_nxt = 1'b1;
        end
      end
      bhc_pkg::CMD_ACK: begin
        pending_nxt = bhc_pkg::CLASS_NONE;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.press_class   = pending_nxt;
    res.op_mode       = mode_nxt;
    res.mode_changed  = changed;
    res.timing_active = running_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r    <= '0;
      rel_r     <= '0;
      last_r    <= 1'b1;
      running_r <= 1'b0;
      pending_r <= bhc_pkg::CLASS_NONE;
      mode_r    <= bhc_pkg::MODE_TRANSMIT;
    end else if (step) begin
      held_r    <= held_nxt;
      rel_r     <= rel_nxt;
      last_r    <= last_nxt;
      running_r <= running_nxt;
      pending_r <= pending_nxt;
      mode_r    <= mode_nxt;
    end
  end

  a_idle_counters_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !running_r |-> (held_r == '0 && rel_r == '0))
    else $error("Counters are nonzero while timing is stopped.");

  a_mode_change_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (step && changed) |=> (!running_r && pending_r == bhc_pkg::CLASS_NONE))
    else $error("A mode advance left timing running or a class pending.");

  a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r != 2'd3)
    else $error("The system mode holds an unused code.");

  a_ack_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step && item.cmd == bhc_pkg::CMD_ACK) |=> pending_r == bhc_pkg::CLASS_NONE)
    else $error("An acknowledge did not clear the pending class.");

endmodule

/* sv/button_hold_classifier_mode_cycle.sv */
// Button hold classifier with system mode cycling. Each transaction on the
// input channel (a millisecond tick with the sampled level, a press edge or an
// acknowledge) yields exactly one result transaction that shows the pending
// class, the system mode, whether the mode advanced and whether timing runs.
// One transaction is taken every cycle unless the sink stalls; it passes an
// input register, one pass of compare-and-count logic and a result register.
// The result register holds while the sink stalls, and the input side then
// stops only once both registers are full. The user must write thresholds on
// the configuration port only while the block is idle; the block does not
// enforce this. Depends on bhc_pkg, bhc_in_if, bhc_out_if and bhc_core.
module button_hold_classifier_mode_cycle (
  input  logic                       clk,
  input  logic                       rst_n,
  bhc_in_if.sink                     in_ch,
  bhc_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [bhc_pkg::CountW-1:0] cfg_data
);

  logic               s1_valid_r;
  bhc_pkg::in_item_t  s1_item_r;
  logic               out_valid_r;
  bhc_pkg::out_item_t out_item_r;
  bhc_pkg::out_item_t core_res;
  bhc_pkg::cfg_t      cfg_r;
  logic               advance;
  logic               in_take;

  assign advance = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_take = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_hold_ticks       <= bhc_pkg::MinHoldReset;
      cfg_r.long_hold_ticks      <= bhc_pkg::LongHoldReset;
      cfg_r.very_long_hold_ticks <= bhc_pkg::VeryLongHoldReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bhc_pkg::REG_MIN_HOLD:       cfg_r.min_hold_ticks       <= cfg_data;
        bhc_pkg::REG_LONG_HOLD:      cfg_r.long_hold_ticks      <= cfg_data;
        bhc_pkg::REG_VERY_LONG_HOLD: cfg_r.very_long_hold_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.cmd          <= in_ch.cmd;
      s1_item_r.button_level <= in_ch.button_level;
    end
  end

  bhc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (s1_item_r),
    .cfg   (cfg_r),
    .res   (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= core_res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.press_class   = out_item_r.press_class;
  assign out_ch.op_mode       = out_item_r.op_mode;
  assign out_ch.mode_changed  = out_item_r.mode_changed;
  assign out_ch.timing_active = out_item_r.timing_active;

endmodule
